FILE: sv/lmcf_pkg.sv
package lmcf_pkg;

  // Default number of driver chips in the chain.
  localparam int MAX_DEVICES_DEF = 8;

  // Reset value of the devices-in-use register.
  localparam logic [3:0] DEV_IN_USE_RESET = 4'd8;

  // One display command.
  typedef struct packed {
    logic [3:0] operation;
    logic [2:0] device;
    logic [2:0] position;
    logic [2:0] column;
    logic [7:0] value;
    logic       flag;
  } cmd_t;

  // One register frame for the chain.
  typedef struct packed {
    logic [2:0] target_device;
    logic [3:0] opcode;
    logic [7:0] data;
    logic       last;
  } frame_t;

  // Command operations.
  typedef enum logic [3:0] {
    OP_LED         = 4'd0,
    OP_ROW         = 4'd1,
    OP_COLUMN      = 4'd2,
    OP_HEX         = 4'd3,
    OP_CHAR        = 4'd4,
    OP_CLEAR       = 4'd5,
    OP_POWER_MODE  = 4'd6,
    OP_DIGIT_LIMIT = 4'd7,
    OP_BRIGHTNESS  = 4'd8
  } op_t;

  // Driver register addresses.
  localparam logic [3:0] OPC_ROW_FIRST = 4'd1;
  localparam logic [3:0] OPC_ROW_LAST  = 4'd8;
  localparam logic [3:0] OPC_INTENSITY = 4'd10;
  localparam logic [3:0] OPC_SCANLIMIT = 4'd11;
  localparam logic [3:0] OPC_SHUTDOWN  = 4'd12;

  localparam logic [7:0] DP_BIT      = 8'h80;
  localparam logic [7:0] COL_MSB     = 8'h80;
  localparam logic [6:0] SPACE_CODE  = 7'd32;
  localparam logic [7:0] HEX_LIMIT   = 8'd16;
  localparam logic [7:0] SCAN_LIMIT  = 8'd8;
  localparam logic [7:0] LEVEL_LIMIT = 8'd16;
  localparam logic [2:0] ROW_LAST    = 3'd7;

  // Segment patterns for codes 0 to 127: bit 7 is the decimal point.
  localparam logic [7:0] SEG_ROM [128] = '{
    8'h7E, 8'h30, 8'h6D, 8'h79, 8'h33, 8'h5B, 8'h5F, 8'h70,
    8'h7F, 8'h7B, 8'h77, 8'h1F, 8'h0D, 8'h3D, 8'h4F, 8'h47,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h80, 8'h01, 8'h80, 8'h00,
    8'h7E, 8'h30, 8'h6D, 8'h79, 8'h33, 8'h5B, 8'h5F, 8'h70,
    8'h7F, 8'h7B, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h77, 8'h1F, 8'h0D, 8'h3D, 8'h4F, 8'h47, 8'h7B,
    8'h37, 8'h00, 8'h00, 8'h00, 8'h0E, 8'h00, 8'h00, 8'h00,
    8'h67, 8'h00, 8'h05, 8'h00, 8'h0F, 8'h1C, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h08,
    8'h00, 8'h77, 8'h1F, 8'h0D, 8'h3D, 8'h4F, 8'h47, 8'h7B,
    8'h37, 8'h00, 8'h00, 8'h00, 8'h0E, 8'h00, 8'h15, 8'h1D,
    8'h67, 8'h00, 8'h05, 8'h00, 8'h0F, 8'h1C, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  // Microprogram addresses.
  typedef logic [3:0] pc_t;
  localparam pc_t PC_LED_RD   = 4'd0;
  localparam pc_t PC_LED_WR   = 4'd1;
  localparam pc_t PC_ROW      = 4'd2;
  localparam pc_t PC_GLYPH    = 4'd3;
  localparam pc_t PC_COL_RD   = 4'd4;
  localparam pc_t PC_COL_WR   = 4'd5;
  localparam pc_t PC_CLEAR    = 4'd6;
  localparam pc_t PC_SHUTDOWN = 4'd7;
  localparam pc_t PC_SCAN     = 4'd8;
  localparam pc_t PC_LEVEL    = 4'd9;

  typedef enum logic [2:0] {
    DSEL_RMW,
    DSEL_VALUE,
    DSEL_GLYPH,
    DSEL_ZERO,
    DSEL_SHUT
  } dsel_t;

  typedef enum logic {
    BSEL_FLAG,
    BSEL_VALUE_BIT
  } bsel_t;

  typedef enum logic [1:0] {
    OSEL_ROW,
    OSEL_INTENSITY,
    OSEL_SCANLIMIT,
    OSEL_SHUTDOWN
  } osel_t;

  // One control word of the sequencer.
  typedef struct packed {
    dsel_t data_sel;
    bsel_t bit_sel;
    osel_t opc_sel;
    logic  emit;
    logic  wr;
    logic  rd;
    logic  rd_next;
    logic  row_inc;
    logic  loop;
    logic  done;
    pc_t   target;
  } ctl_t;

  // Control store. A loop step jumps to its target until row 7 has been handled.
  function automatic ctl_t ucode(input pc_t pc);
    ctl_t c;
    c = '0;
    c.data_sel = DSEL_ZERO;
    c.bit_sel  = BSEL_FLAG;
    c.opc_sel  = OSEL_ROW;
    c.target   = pc;
    unique case (pc)
      PC_LED_RD: begin
        c.rd = 1'b1;
      end
      PC_LED_WR: begin
        c.data_sel = DSEL_RMW;
        c.emit     = 1'b1;
        c.wr       = 1'b1;
        c.done     = 1'b1;
      end
      PC_ROW: begin
        c.data_sel = DSEL_VALUE;
        c.emit     = 1'b1;
        c.wr       = 1'b1;
        c.done     = 1'b1;
      end
      PC_GLYPH: begin
        c.data_sel = DSEL_GLYPH;
        c.emit     = 1'b1;
        c.wr       = 1'b1;
        c.done     = 1'b1;
      end
      PC_COL_RD: begin
        c.rd = 1'b1;
      end
      PC_COL_WR: begin
        c.data_sel = DSEL_RMW;
        c.bit_sel  = BSEL_VALUE_BIT;
        c.emit     = 1'b1;
        c.wr       = 1'b1;
        c.rd       = 1'b1;
        c.rd_next  = 1'b1;
        c.row_inc  = 1'b1;
        c.loop     = 1'b1;
        c.target   = PC_COL_WR;
      end
      PC_CLEAR: begin
        c.data_sel = DSEL_ZERO;
        c.emit     = 1'b1;
        c.wr       = 1'b1;
        c.row_inc  = 1'b1;
        c.loop     = 1'b1;
        c.target   = PC_CLEAR;
      end
      PC_SHUTDOWN: begin
        c.data_sel = DSEL_SHUT;
        c.opc_sel  = OSEL_SHUTDOWN;
        c.emit     = 1'b1;
        c.done     = 1'b1;
      end
      PC_SCAN: begin
        c.data_sel = DSEL_VALUE;
        c.opc_sel  = OSEL_SCANLIMIT;
        c.emit     = 1'b1;
        c.done     = 1'b1;
      end
      PC_LEVEL: begin
        c.data_sel = DSEL_VALUE;
        c.opc_sel  = OSEL_INTENSITY;
        c.emit     = 1'b1;
        c.done     = 1'b1;
      end
      default: begin
        c.done = 1'b1;
      end
    endcase
    return c;
  endfunction

endpackage

FILE: sv/lmcf_shadow.sv
// Row shadow store with one write and one registered read port.
// Entries that were never written since reset read as zero.
module lmcf_shadow #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0]       mem [DEPTH];
  logic [DEPTH-1:0] written_r;
  logic [7:0]       mem_q_r;
  logic             vld_q_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r <= '0;
      vld_q_r   <= 1'b0;
    end else begin
      if (wr_en) begin
        written_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        vld_q_r <= written_r[rd_addr];
      end
    end
  end

  assign rd_data = vld_q_r ? mem_q_r : 8'h00;

endmodule

FILE: sv/led_matrix_command_framer.sv
// A row, glyph or control register command passes the step register and then
// the frame register; a single-LED command first reads its shadow row; column
// commands read row 0 first; column and clear then give one frame every cycle.
// Busy stays high for all microprogram steps of a command, so no new command is
// taken until it ends; frames cannot stall.
// Reset (synchronous, active low) empties the row shadow and sets 8 devices.
module led_matrix_command_framer #(
  parameter int MAX_DEVICES = lmcf_pkg::MAX_DEVICES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  // Command channel: a transaction happens when start is high and busy is low.
  input  logic             start,
  output logic             busy,
  input  lmcf_pkg::cmd_t   in_cmd,
  // Frame channel: each frame is shown for one cycle, marked by out_valid.
  output logic             out_valid,
  output lmcf_pkg::frame_t out_frame,
  // Devices-in-use register.
  input  logic             cfg_we,
  input  logic [3:0]       cfg_data
);

  // The shadow holds eight rows for each chip; a row's address is {device, row}.
  localparam int DEPTH  = MAX_DEVICES * 8;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam logic [3:0] MAX_DEV_C = 4'(MAX_DEVICES);

  logic [3:0] dev_in_use_r;

  // Command fields held for the whole transaction; the row advances in loop steps.
  logic [2:0] dev_r,   dev_nxt;
  logic [2:0] row_r,   row_nxt;
  logic [2:0] col_r,   col_nxt;
  logic [7:0] value_r, value_nxt;
  logic       flag_r,  flag_nxt;
  logic [6:0] glyph_r, glyph_nxt;

  // Sequencer state.
  lmcf_pkg::pc_t pc_r, pc_nxt;
  logic          run_r, run_nxt;

  // Frame register.
  logic             out_valid_r, out_valid_nxt;
  lmcf_pkg::frame_t frame_r,     frame_nxt;

  lmcf_pkg::ctl_t    ctl;
  logic              accept;
  logic              cmd_ok;
  lmcf_pkg::pc_t     entry_pc;
  logic [2:0]        entry_row;
  logic [6:0]        entry_glyph;
  logic              dev_ok;
  logic              step_last;

  logic [7:0]        shadow_q;
  logic [7:0]        col_mask;
  logic              new_bit;
  logic [7:0]        rmw_data;
  logic [7:0]        frame_data;
  logic [3:0]        frame_opc;
  logic [2:0]        rd_row;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;

  assign busy   = run_r;
  assign accept = start && !run_r;

  // Configuration register, to be written only while the block is idle; the block does not enforce this.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_in_use_r <= lmcf_pkg::DEV_IN_USE_RESET;
    end else if (cfg_we) begin
      dev_in_use_r <= cfg_data;
    end
  end

  // Decode of a new command: choose the microprogram entry and drop commands
  // whose operation, device or argument is out of range, so they never start.
  assign dev_ok = ({1'b0, in_cmd.device} < dev_in_use_r) &&
                  ({1'b0, in_cmd.device} < MAX_DEV_C);

  always_comb begin
    cmd_ok      = 1'b1;
    entry_pc    = lmcf_pkg::PC_ROW;
    entry_row   = in_cmd.position;
    entry_glyph = in_cmd.value[6:0];
    unique case (in_cmd.operation)
      lmcf_pkg::OP_LED: begin
        entry_pc = lmcf_pkg::PC_LED_RD;
      end
      lmcf_pkg::OP_ROW: begin
        entry_pc = lmcf_pkg::PC_ROW;
      end
      lmcf_pkg::OP_COLUMN: begin
        entry_pc  = lmcf_pkg::PC_COL_RD;
        entry_row = '0;
      end
      lmcf_pkg::OP_HEX: begin
        entry_pc = lmcf_pkg::PC_GLYPH;
        cmd_ok   = in_cmd.value < lmcf_pkg::HEX_LIMIT;
      end
      lmcf_pkg::OP_CHAR: begin
        entry_pc = lmcf_pkg::PC_GLYPH;
        // Codes above 127 are drawn as a blank.
        if (in_cmd.value[7]) begin
          entry_glyph = lmcf_pkg::SPACE_CODE;
        end
      end
      lmcf_pkg::OP_CLEAR: begin
        entry_pc  = lmcf_pkg::PC_CLEAR;
        entry_row = '0;
      end
      lmcf_pkg::OP_POWER_MODE: begin
        entry_pc = lmcf_pkg::PC_SHUTDOWN;
      end
      lmcf_pkg::OP_DIGIT_LIMIT: begin
        entry_pc = lmcf_pkg::PC_SCAN;
        cmd_ok   = in_cmd.value < lmcf_pkg::SCAN_LIMIT;
      end
      lmcf_pkg::OP_BRIGHTNESS: begin
        entry_pc = lmcf_pkg::PC_LEVEL;
        cmd_ok   = in_cmd.value < lmcf_pkg::LEVEL_LIMIT;
      end
      default: begin
        cmd_ok = 1'b0;
      end
    endcase
  end

  // The control word of the current step drives the datapath below.
  assign ctl = lmcf_pkg::ucode(pc_r);

  // A loop step ends the program after row 7; the step that ends it carries
  // the last frame of the transaction.
  assign step_last = ctl.done || (ctl.loop && (row_r == lmcf_pkg::ROW_LAST));

  // Read-modify-write of one shadow row. Column commands take row r's bit from
  // value bit 7-r, which for a three-bit row is its complement.
  assign col_mask = lmcf_pkg::COL_MSB >> col_r;
  assign new_bit  = (ctl.bit_sel == lmcf_pkg::BSEL_FLAG) ? flag_r : value_r[~row_r];
  assign rmw_data = new_bit ? (shadow_q | col_mask) : (shadow_q & ~col_mask);

  always_comb begin
    unique case (ctl.data_sel)
      lmcf_pkg::DSEL_RMW:   frame_data = rmw_data;
      lmcf_pkg::DSEL_VALUE: frame_data = value_r;
      lmcf_pkg::DSEL_GLYPH: frame_data = lmcf_pkg::SEG_ROM[glyph_r] |
                                         (flag_r ? lmcf_pkg::DP_BIT : 8'h00);
      lmcf_pkg::DSEL_SHUT:  frame_data = {7'd0, ~flag_r};
      default:              frame_data = 8'h00;
    endcase
  end

  always_comb begin
    unique case (ctl.opc_sel)
      lmcf_pkg::OSEL_ROW:       frame_opc = {1'b0, row_r} + lmcf_pkg::OPC_ROW_FIRST;
      lmcf_pkg::OSEL_INTENSITY: frame_opc = lmcf_pkg::OPC_INTENSITY;
      lmcf_pkg::OSEL_SCANLIMIT: frame_opc = lmcf_pkg::OPC_SCANLIMIT;
      default:                  frame_opc = lmcf_pkg::OPC_SHUTDOWN;
    endcase
  end

  // While a column is being written, the next row is fetched in the same step,
  // so one frame leaves every cycle.
  assign rd_row  = ctl.rd_next ? (row_r + 3'd1) : row_r;
  assign wr_addr = ADDR_W'({dev_r, row_r});
  assign rd_addr = ADDR_W'({dev_r, rd_row});

  lmcf_shadow #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_shadow (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (run_r && ctl.wr),
    .wr_addr (wr_addr),
    .wr_data (frame_data),
    .rd_en   (run_r && ctl.rd),
    .rd_addr (rd_addr),
    .rd_data (shadow_q)
  );

  // Sequencer next state: step counter, conditional loop back and the latch
  // of a newly accepted command.
  always_comb begin
    pc_nxt    = pc_r;
    run_nxt   = run_r;
    dev_nxt   = dev_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    value_nxt = value_r;
    flag_nxt  = flag_r;
    glyph_nxt = glyph_r;
    priority if (run_r) begin
      if (ctl.row_inc) begin
        row_nxt = row_r + 3'd1;
      end
      if (step_last) begin
        run_nxt = 1'b0;
      end else if (ctl.loop) begin
        pc_nxt = ctl.target;
      end else begin
        pc_nxt = pc_r + 4'd1;
      end
    end else if (accept) begin
      run_nxt   = dev_ok && cmd_ok;
      pc_nxt    = entry_pc;
      dev_nxt   = in_cmd.device;
      row_nxt   = entry_row;
      col_nxt   = in_cmd.column;
      value_nxt = in_cmd.value;
      flag_nxt  = in_cmd.flag;
      glyph_nxt = entry_glyph;
    end
  end

  // Frame register next value.
  always_comb begin
    out_valid_nxt           = run_r && ctl.emit;
    frame_nxt.target_device = dev_r;
    frame_nxt.opcode        = frame_opc;
    frame_nxt.data          = frame_data;
    frame_nxt.last          = step_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r       <= 1'b0;
      pc_r        <= lmcf_pkg::PC_ROW;
      out_valid_r <= 1'b0;
    end else begin
      run_r       <= run_nxt;
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dev_r   <= dev_nxt;
    row_r   <= row_nxt;
    col_r   <= col_nxt;
    value_r <= value_nxt;
    flag_r  <= flag_nxt;
    glyph_r <= glyph_nxt;
    frame_r <= frame_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_frame = frame_r;

endmodule

FILE: sv/lmcf_checker.sv
// Port-level checks of the command framer.
module lmcf_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             busy,
  input logic             out_valid,
  input lmcf_pkg::frame_t out_frame
);

  // Frames of one transaction follow each other without gaps.
  a_frames_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_frame.last |=> out_valid)
    else $error("frame train broken before its last frame");

  // The block stays busy while a transaction still has frames to give.
  a_busy_until_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_frame.last |-> busy)
    else $error("not busy while frames are pending");

  // Busy ends together with the last frame of the transaction.
  a_busy_ends_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $fell(busy) |-> out_valid && out_frame.last)
    else $error("busy fell without a last frame");

  // Only driver register addresses that the framer knows are sent.
  a_opcode_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_frame.opcode >= lmcf_pkg::OPC_ROW_FIRST &&
                   out_frame.opcode <= lmcf_pkg::OPC_ROW_LAST) ||
                  out_frame.opcode == lmcf_pkg::OPC_INTENSITY ||
                  out_frame.opcode == lmcf_pkg::OPC_SCANLIMIT ||
                  out_frame.opcode == lmcf_pkg::OPC_SHUTDOWN)
    else $error("unknown opcode in frame");

endmodule

bind led_matrix_command_framer lmcf_checker u_lmcf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .busy      (busy),
  .out_valid (out_valid),
  .out_frame (out_frame)
);
